### src/vtv_pkg.sv
`default_nettype none
package vtv_pkg;

	localparam int unsigned DIV_STEPS = 33;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [32:0] Q_ONE   = 33'sd65536;
	localparam logic signed [31:0] Q_HALF  = 32'sd32768;

	typedef enum logic [2:0] {
		REG_ROW0   = 3'd0,
		REG_ROW1   = 3'd1,
		REG_ROW2   = 3'd2,
		REG_ROW3   = 3'd3,
		REG_ORG_X  = 3'd4,
		REG_ORG_Y  = 3'd5,
		REG_HALF_W = 3'd6,
		REG_HALF_H = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
		logic               batch_end;
	} vtx_in_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic signed [31:0] recip_w;
		logic signed [31:0] persp_u;
		logic signed [31:0] persp_v;
		logic               w_was_zero;
		logic               batch_last;
	} vtx_out_t;

	// values that ride alongside the reciprocal pipeline
	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] tu;
		logic signed [31:0] tv;
		logic               batch;
	} side_t;

	typedef struct packed {
		side_t              side;
		logic signed [31:0] cw;
	} clip_t;

	typedef struct packed {
		side_t              side;
		logic signed [31:0] rw;
		logic               wz;
	} recip_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'(S32_MAX))
			r = S32_MAX;
		else if (v < 66'(S32_MIN))
			r = S32_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

### src/vtv_clip.sv
`default_nettype none
module vtv_clip (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire vtv_pkg::vtx_in_t vin,
	input  wire logic [63:0]     row_x,
	input  wire logic [63:0]     row_y,
	input  wire logic [63:0]     row_w,
	output logic                 out_valid,
	output vtv_pkg::clip_t       out
);

	logic              valid_s1;
	logic signed [47:0] prod_s1 [3][3];
	vtv_pkg::side_t    side_s1;

	logic [63:0] rows [3];
	assign rows[0] = row_x;
	assign rows[1] = row_y;
	assign rows[2] = row_w;

	logic signed [31:0] pos [3];
	assign pos[0] = vin.pos_x;
	assign pos[1] = vin.pos_y;
	assign pos[2] = vin.pos_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s1[r][c] <= 48'($signed(rows[r][16*c +: 16])) * 48'(pos[c]);
			end
		end
		side_s1.cx    <= '0;
		side_s1.cy    <= '0;
		side_s1.tu    <= vin.tex_u;
		side_s1.tv    <= vin.tex_v;
		side_s1.batch <= vin.batch_end;
	end

	// sum in Q.28, floor to Q16.16; w input is 1.0 so column 3 is a shift
	logic signed [31:0] clip_val [3];
	always_comb begin
		logic signed [49:0] acc;
		logic signed [15:0] c3;
		for (int r = 0; r < 3; r++) begin
			c3  = $signed(rows[r][63:48]);
			acc = 50'(prod_s1[r][0]) + 50'(prod_s1[r][1]) + 50'(prod_s1[r][2])
				+ {{18{c3[15]}}, c3, 16'b0};
			clip_val[r] = vtv_pkg::sat32(66'(acc >>> 12));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else
			out_valid <= valid_s1;
	end

	always_ff @(posedge clk) begin
		out.side.cx    <= clip_val[0];
		out.side.cy    <= clip_val[1];
		out.side.tu    <= side_s1.tu;
		out.side.tv    <= side_s1.tv;
		out.side.batch <= side_s1.batch;
		out.cw         <= clip_val[2];
	end

endmodule
`default_nettype wire

### src/vtv_recip.sv
`default_nettype none
module vtv_recip (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire vtv_pkg::clip_t in,
	output logic                out_valid,
	output vtv_pkg::recip_t     out
);

	localparam int unsigned N = vtv_pkg::DIV_STEPS;

	// restoring division of 2^32 by |cw|, one quotient bit per stage
	logic           v_s   [N+1];
	logic [31:0]    d_s   [N+1];
	logic [31:0]    rem_s [N+1];
	logic [32:0]    q_s   [N+1];
	logic           neg_s [N+1];
	logic           zero_s[N+1];
	vtv_pkg::side_t side_s[N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else
			v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		d_s[0]    <= in.cw[31] ? 32'(-in.cw) : 32'(in.cw);
		rem_s[0]  <= '0;
		q_s[0]    <= '0;
		neg_s[0]  <= in.cw[31];
		zero_s[0] <= (in.cw == '0);
		side_s[0] <= in.side;
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [32:0] sh;
		logic        ge;
		assign sh = {rem_s[k], (k == 0) ? 1'b1 : 1'b0};
		assign ge = (sh >= {1'b0, d_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k+1] <= 1'b0;
			else
				v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? 32'(sh - {1'b0, d_s[k]}) : sh[31:0];
			q_s[k+1]    <= {q_s[k][31:0], ge};
			d_s[k+1]    <= d_s[k];
			neg_s[k+1]  <= neg_s[k];
			zero_s[k+1] <= zero_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	logic signed [31:0] rw;
	always_comb begin
		if (zero_s[N])
			rw = vtv_pkg::S32_MAX;
		else if (neg_s[N])
			rw = vtv_pkg::sat32(-$signed({33'b0, q_s[N]}));
		else
			rw = vtv_pkg::sat32($signed({33'b0, q_s[N]}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else
			out_valid <= v_s[N];
	end

	always_ff @(posedge clk) begin
		out.side <= side_s[N];
		out.rw   <= rw;
		out.wz   <= zero_s[N];
	end

endmodule
`default_nettype wire

### src/vtv_project.sv
`default_nettype none
module vtv_project (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire vtv_pkg::recip_t in,
	input  wire logic [31:0]     org_x,
	input  wire logic [31:0]     org_y,
	input  wire logic [30:0]     half_w,
	input  wire logic [30:0]     half_h,
	output logic                 out_valid,
	output vtv_pkg::vtx_out_t    out
);

	// s1: four products against 1/w, Q16.16 by Q16.16 into Q32.32
	logic               valid_s1, valid_s2, valid_s3;
	logic signed [63:0] px_s1, py_s1, pu_s1, pv_s1;
	logic signed [31:0] rw_s1, rw_s2, rw_s3;
	logic               wz_s1, wz_s2, wz_s3, bt_s1, bt_s2, bt_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= 64'(in.side.cx) * 64'(in.rw);
		py_s1 <= 64'(in.side.cy) * 64'(in.rw);
		pu_s1 <= 64'(in.side.tu) * 64'(in.rw);
		pv_s1 <= 64'(in.side.tv) * 64'(in.rw);
		rw_s1 <= in.rw;
		wz_s1 <= in.wz;
		bt_s1 <= in.side.batch;
	end

	// s2: floor and saturate
	logic signed [31:0] nx_s2, ny_s2, pu_s2, pv_s2, pu_s3, pv_s3;

	always_ff @(posedge clk) begin
		nx_s2 <= vtv_pkg::sat32(66'(px_s1 >>> 16));
		ny_s2 <= vtv_pkg::sat32(66'(py_s1 >>> 16));
		pu_s2 <= vtv_pkg::sat32(66'(pu_s1 >>> 16));
		pv_s2 <= vtv_pkg::sat32(66'(pv_s1 >>> 16));
		rw_s2 <= rw_s1;
		wz_s2 <= wz_s1;
		bt_s2 <= bt_s1;
	end

	// s3: (ndc + 1.0) * half extent
	logic signed [64:0] tx_s3, ty_s3;

	always_ff @(posedge clk) begin
		tx_s3 <= 65'(33'(nx_s2) + vtv_pkg::Q_ONE) * 65'($signed({1'b0, half_w}));
		ty_s3 <= 65'(33'(ny_s2) + vtv_pkg::Q_ONE) * 65'($signed({1'b0, half_h}));
		pu_s3 <= pu_s2;
		pv_s3 <= pv_s2;
		rw_s3 <= rw_s2;
		wz_s3 <= wz_s2;
		bt_s3 <= bt_s2;
	end

	// s4: add origin and the half-pixel offset
	logic signed [65:0] sx, sy;
	assign sx = 66'(tx_s3 >>> 16) + 66'($signed(org_x)) + 66'(vtv_pkg::Q_HALF);
	assign sy = 66'(ty_s3 >>> 16) + 66'($signed(org_y)) + 66'(vtv_pkg::Q_HALF);

	always_ff @(posedge clk) begin
		out.screen_x   <= vtv_pkg::sat32(sx);
		out.screen_y   <= vtv_pkg::sat32(sy);
		out.recip_w    <= rw_s3;
		out.persp_u    <= pu_s3;
		out.persp_v    <= pv_s3;
		out.w_was_zero <= wz_s3;
		out.batch_last <= bt_s3;
	end

endmodule
`default_nettype wire

### src/vertex_transform_viewport_core.sv
// channel   | handshake           | payload
// ----------+---------------------+-----------------------------
// vertex    | start, busy         | vertex (vtx_in_t)
// result    | done (strobe)       | result (vtx_out_t)
// config    | cfg_we              | cfg_idx, cfg_wdata
//
// One vertex per cycle; busy never rises. The path runs through the matrix
// stage, the 33-step reciprocal pipeline and the projection/viewport stage.
// Reset clears valid bits and configuration; payload registers are not reset.
// Results cannot be held off; each appears for one cycle with done.
`default_nettype none
module vertex_transform_viewport_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire vtv_pkg::vtx_in_t  vertex,
	output logic                   done,
	output vtv_pkg::vtx_out_t      result,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_idx,
	input  wire logic [63:0]       cfg_wdata
);

	logic [63:0] row_x_q, row_y_q, row_w_q;
	logic [31:0] org_x_q, org_y_q;
	logic [30:0] half_w_q, half_h_q;

	// row 2 would only feed clip z, which nothing uses, so writes to it are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q  <= '0;
			row_y_q  <= '0;
			row_w_q  <= '0;
			org_x_q  <= '0;
			org_y_q  <= '0;
			half_w_q <= '0;
			half_h_q <= '0;
		end else if (cfg_we) begin
			case (vtv_pkg::reg_idx_t'(cfg_idx))
				vtv_pkg::REG_ROW0:   row_x_q  <= cfg_wdata;
				vtv_pkg::REG_ROW1:   row_y_q  <= cfg_wdata;
				vtv_pkg::REG_ROW3:   row_w_q  <= cfg_wdata;
				vtv_pkg::REG_ORG_X:  org_x_q  <= cfg_wdata[31:0];
				vtv_pkg::REG_ORG_Y:  org_y_q  <= cfg_wdata[31:0];
				vtv_pkg::REG_HALF_W: half_w_q <= cfg_wdata[30:0];
				vtv_pkg::REG_HALF_H: half_h_q <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic            clip_valid, recip_valid;
	vtv_pkg::clip_t  clip;
	vtv_pkg::recip_t recip;

	vtv_clip u_clip (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.vin       (vertex),
		.row_x     (row_x_q),
		.row_y     (row_y_q),
		.row_w     (row_w_q),
		.out_valid (clip_valid),
		.out       (clip)
	);

	vtv_recip u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (clip_valid),
		.in        (clip),
		.out_valid (recip_valid),
		.out       (recip)
	);

	vtv_project u_project (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (recip_valid),
		.in        (recip),
		.org_x     (org_x_q),
		.org_y     (org_y_q),
		.half_w    (half_w_q),
		.half_h    (half_h_q),
		.out_valid (done),
		.out       (result)
	);

endmodule
`default_nettype wire
